[sv/bagsel_pkg.sv]
// Shared constants, field types and control structs for the best-arm gap selector.
// Depends on nothing; every other file of the block but bagsel_ram imports it.
package bagsel_pkg;

  localparam int MAX_ARMS    = 64;
  localparam int ID_W        = 10;
  localparam int BOUND_W     = 32;
  localparam int TAG_W       = 16;
  localparam int EPS_W       = 31;
  localparam int DIFF_W      = BOUND_W + 1;
  localparam int IDX_W       = $clog2(MAX_ARMS);
  localparam int CNT_W       = $clog2(MAX_ARMS + 1);
  localparam int RAM_DEPTH   = 2 * MAX_ARMS;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = EPS_W;

  localparam logic [CFG_IDX_W-1:0] CFG_GAP_EPSILON  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_FEATURE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [BOUND_W-1:0] lower;
    logic signed [BOUND_W-1:0] upper;
    logic [TAG_W-1:0]          tag;
  } arm_word_t;

  localparam int ARM_W = $bits(arm_word_t);

  // Summary of one closed set, handed from the loader to the scanner.
  typedef struct packed {
    logic                      bank;
    logic [CNT_W-1:0]          count;
    logic                      err;
    logic [ID_W-1:0]           first_id;
    arm_word_t                 ldr;
    logic                      stop_present;
    logic signed [BOUND_W-1:0] stop_lower;
  } set_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    logic [EPS_W-1:0] gap_epsilon;
    logic [ID_W-1:0]  stop_feature;
  } cfg_t;

endpackage

[sv/bagsel_if.sv]
// Valid/ready channel interfaces for arm items and selection results.
// Depends on bagsel_pkg for field widths.
interface bagsel_in_if import bagsel_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ID_W-1:0]           feature_id;
  logic signed [BOUND_W-1:0] lower_bound;
  logic signed [BOUND_W-1:0] upper_bound;
  logic [TAG_W-1:0]          group_tag;
  logic                      last_arm;

  modport source (output valid, feature_id, lower_bound, upper_bound, group_tag, last_arm,
                  input ready);
  modport sink (input valid, feature_id, lower_bound, upper_bound, group_tag, last_arm,
                output ready);
endinterface

interface bagsel_out_if import bagsel_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] chosen_arm;
  logic [ID_W-1:0] leader_arm;
  logic [ID_W-1:0] best_arm;
  logic            stop_found;
  logic            all_same_error;

  modport source (output valid, chosen_arm, leader_arm, best_arm, stop_found, all_same_error,
                  input ready);
  modport sink (input valid, chosen_arm, leader_arm, best_arm, stop_found, all_same_error,
                output ready);
endinterface

[sv/best_arm_gap_selector_unit.sv]
// Top level of the best-arm gap selector: configuration registers, arm RAM, loader,
// set queue and scanner. Depends on bagsel_pkg, bagsel_if and the bagsel_* modules.
//
//   Channel   Direction  Handshake            Payload
//   in_arm    in         valid/ready          feature_id, lower_bound, upper_bound,
//                                             group_tag, last_arm
//   out_res   out        valid/ready          chosen_arm, leader_arm, best_arm,
//                                             stop_found, all_same_error
//   cfg_*     in         cfg_we, no wait      cfg_index, cfg_wdata
//
// The loader takes one arm per cycle while in_arm.ready is high. After its last arm,
// a set passes the scanner in steps: a queue pop, one RAM read per stored arm, a
// wait for the registered read data, a step that closes the scan, a difference step
// and an output step. A set whose tags all match skips the scan and difference
// steps and goes from the pop straight to the output step.
// The RAM holds two banks, so the next set loads while the previous one is scanned;
// in_arm.ready drops only when the loader's bank still holds a set that is queued
// or being scanned.
// Reset is synchronous and active low; it clears control state and both
// configuration registers, and no clearing pass is needed.
// The output register frees the scanner as soon as a result is taken, and a stall
// on out_res backs up through the queue to in_arm without losing anything.
module best_arm_gap_selector_unit import bagsel_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bagsel_in_if.sink            in_arm,
  bagsel_out_if.source         out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t              cfg_r, cfg_nxt;
  bank_rel_t         rel;
  logic              q_full, q_empty, q_push, q_pop;
  set_desc_t         q_push_desc, q_head;
  logic              wr_en, rd_en;
  logic [RAM_AW-1:0] wr_addr, rd_addr;
  arm_word_t         wr_data, rd_data;

  // Configuration writes must be issued only while the block is idle, so no
  // shadowing is needed; the block itself does not enforce this.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_GAP_EPSILON:  cfg_nxt.gap_epsilon  = cfg_wdata[EPS_W-1:0];
        CFG_STOP_FEATURE: cfg_nxt.stop_feature = cfg_wdata[ID_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Arm storage: bank bit on top of the arm index.
  bagsel_ram #(
    .WIDTH (ARM_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bagsel_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_arm    (in_arm),
    .cfg       (cfg_r),
    .rel       (rel),
    .q_full    (q_full),
    .push      (q_push),
    .push_desc (q_push_desc),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  bagsel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  bagsel_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .rel     (rel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .out_res (out_res)
  );

endmodule

[sv/bagsel_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; width and depth come from its parameters.
module bagsel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/bagsel_front.sv]
// Arm loader: takes arm transfers, writes them to the arm RAM, tracks the leader,
// tag spread and stop feature, and queues a set summary on the last arm. Uses bagsel_pkg.
module bagsel_front import bagsel_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bagsel_in_if.sink         in_arm,
  input  cfg_t              cfg,
  input  bank_rel_t         rel,
  input  logic              q_full,
  output logic              push,
  output set_desc_t         push_desc,
  output logic              wr_en,
  output logic [RAM_AW-1:0] wr_addr,
  output arm_word_t         wr_data
);

  logic                      bank_r, bank_nxt;
  logic [1:0]                busy_r, busy_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt, count_upd;
  logic                      differ_r, differ_nxt, differ_upd;
  logic                      present_r, present_nxt, present_upd;
  logic signed [BOUND_W-1:0] stop_lower_r, stop_lower_upd;
  arm_word_t                 ldr_r, ldr_upd;
  logic [ID_W-1:0]           first_id_r, first_id_upd;
  logic [TAG_W-1:0]          first_tag_r, first_tag_upd;
  arm_word_t                 arm;
  logic                      accept, store, close;

  assign in_arm.ready = !busy_r[bank_r] && !q_full;

  always_comb begin
    arm.id    = in_arm.feature_id;
    arm.lower = in_arm.lower_bound;
    arm.upper = in_arm.upper_bound;
    arm.tag   = in_arm.group_tag;
    accept    = in_arm.valid && in_arm.ready;
    // Arms past the RAM capacity are dropped, but their last flag still counts.
    store     = accept && (count_r != CNT_W'(MAX_ARMS));
    close     = accept && in_arm.last_arm;

    count_upd      = count_r;
    differ_upd     = differ_r;
    present_upd    = present_r;
    stop_lower_upd = stop_lower_r;
    ldr_upd        = ldr_r;
    first_id_upd   = first_id_r;
    first_tag_upd  = first_tag_r;

    if (store) begin
      count_upd = count_r + 1'b1;
      if (count_r == '0) begin
        ldr_upd       = arm;
        first_id_upd  = arm.id;
        first_tag_upd = arm.tag;
      end else begin
        if (arm.tag != first_tag_r) begin
          differ_upd = 1'b1;
        end
        // Strict compare keeps the earliest arm on a tie.
        if (arm.lower > ldr_r.lower) begin
          ldr_upd = arm;
        end
      end
      if (!present_r && (arm.id == cfg.stop_feature)) begin
        present_upd    = 1'b1;
        stop_lower_upd = arm.lower;
      end
    end

    push                   = close;
    push_desc.bank         = bank_r;
    push_desc.count        = count_upd;
    push_desc.err          = !differ_upd;
    push_desc.first_id     = first_id_upd;
    push_desc.ldr          = ldr_upd;
    push_desc.stop_present = present_upd;
    push_desc.stop_lower   = stop_lower_upd;

    count_nxt   = count_upd;
    differ_nxt  = differ_upd;
    present_nxt = present_upd;
    bank_nxt    = bank_r;
    if (close) begin
      count_nxt   = '0;
      differ_nxt  = 1'b0;
      present_nxt = 1'b0;
      bank_nxt    = !bank_r;
    end

    busy_nxt = busy_r;
    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end
    if (close) begin
      busy_nxt[bank_r] = 1'b1;
    end

    wr_en   = store;
    wr_addr = {bank_r, count_r[IDX_W-1:0]};
    wr_data = arm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r    <= 1'b0;
      busy_r    <= '0;
      count_r   <= '0;
      differ_r  <= 1'b0;
      present_r <= 1'b0;
    end else begin
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
      count_r   <= count_nxt;
      differ_r  <= differ_nxt;
      present_r <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stop_lower_r <= stop_lower_upd;
    ldr_r        <= ldr_upd;
    first_id_r   <= first_id_upd;
    first_tag_r  <= first_tag_upd;
  end

endmodule

[sv/bagsel_queue.sv]
// Small FIFO of closed-set summaries between the loader and the scanner.
// Uses bagsel_pkg for the summary type and depth.
module bagsel_queue import bagsel_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  set_desc_t push_desc,
  input  logic      pop,
  output set_desc_t head,
  output logic      empty,
  output logic      full
);

  set_desc_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  always_comb begin
    empty   = (cnt_r == '0);
    full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    head    = slot_r[rd_ptr_r];
    do_push = push && !full;
    do_pop  = pop && !empty;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

[sv/bagsel_back.sv]
// Set scanner: rereads a mixed-tag set from the arm RAM to find the challenger, forms
// the gap and width tests and holds the result in an output register. Uses bagsel_pkg.
module bagsel_back import bagsel_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              q_empty,
  input  set_desc_t         q_head,
  output logic              q_pop,
  output bank_rel_t         rel,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  arm_word_t         rd_data,
  bagsel_out_if.source      out_res
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                state_r, state_nxt;
  set_desc_t                 desc_r, desc_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      pend_r, pend_nxt;
  logic                      have_c_r, have_c_nxt;
  arm_word_t                 c_r, c_nxt;
  logic signed [DIFF_W-1:0]  gap_r, gap_nxt, lgap_r, lgap_nxt;
  logic signed [DIFF_W-1:0]  wb_r, wb_nxt, wc_r, wc_nxt;
  logic signed [DIFF_W-1:0]  eps;
  logic                      out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]           chosen_r, chosen_nxt, leader_r, leader_nxt, best_r, best_nxt;
  logic                      stop_r, stop_nxt, err_r, err_nxt;
  logic                      slot_free, stop_now;

  function automatic logic signed [DIFF_W-1:0] sx(input logic signed [BOUND_W-1:0] v);
    return {v[BOUND_W-1], v};
  endfunction

  assign out_res.valid          = out_valid_r;
  assign out_res.chosen_arm     = chosen_r;
  assign out_res.leader_arm     = leader_r;
  assign out_res.best_arm       = best_r;
  assign out_res.stop_found     = stop_r;
  assign out_res.all_same_error = err_r;

  always_comb begin
    state_nxt     = state_r;
    desc_nxt      = desc_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    have_c_nxt    = have_c_r;
    c_nxt         = c_r;
    gap_nxt       = gap_r;
    lgap_nxt      = lgap_r;
    wb_nxt        = wb_r;
    wc_nxt        = wc_r;
    chosen_nxt    = chosen_r;
    leader_nxt    = leader_r;
    best_nxt      = best_r;
    stop_nxt      = stop_r;
    err_nxt       = err_r;
    q_pop         = 1'b0;
    rel.valid     = 1'b0;
    rel.bank      = desc_r.bank;
    rd_en         = 1'b0;
    rd_addr       = {desc_r.bank, idx_r[IDX_W-1:0]};
    eps           = $signed({{(DIFF_W - EPS_W){1'b0}}, cfg.gap_epsilon});
    slot_free     = !out_valid_r || out_res.ready;
    stop_now      = (gap_r <= eps);
    out_valid_nxt = out_valid_r && !out_res.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          desc_nxt = q_head;
          idx_nxt  = '0;
          have_c_nxt = 1'b0;
          if (q_head.err) begin
            // No scan is needed when every tag matches; the bank is free at once.
            rel.valid = 1'b1;
            rel.bank  = q_head.bank;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = (idx_r != desc_r.count);
        if (rd_en) begin
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r && (rd_data.tag != desc_r.ldr.tag) &&
            (!have_c_r || (rd_data.upper > c_r.upper))) begin
          c_nxt      = rd_data;
          have_c_nxt = 1'b1;
        end
        if (!rd_en && !pend_r) begin
          rel.valid = 1'b1;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        gap_nxt   = sx(c_r.upper) - sx(desc_r.ldr.lower);
        lgap_nxt  = sx(desc_r.ldr.lower) - sx(desc_r.stop_lower);
        wb_nxt    = sx(desc_r.ldr.upper) - sx(desc_r.ldr.lower);
        wc_nxt    = sx(c_r.upper) - sx(c_r.lower);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (desc_r.err) begin
            chosen_nxt = desc_r.first_id;
            leader_nxt = desc_r.first_id;
            best_nxt   = desc_r.first_id;
            stop_nxt   = 1'b1;
            err_nxt    = 1'b1;
          end else begin
            leader_nxt = desc_r.ldr.id;
            chosen_nxt = (wc_r > wb_r) ? c_r.id : desc_r.ldr.id;
            best_nxt   = (stop_now && desc_r.stop_present && (lgap_r <= eps)) ?
                         cfg.stop_feature : desc_r.ldr.id;
            stop_nxt   = stop_now;
            err_nxt    = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      have_c_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      have_c_r    <= have_c_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r   <= desc_nxt;
    c_r      <= c_nxt;
    gap_r    <= gap_nxt;
    lgap_r   <= lgap_nxt;
    wb_r     <= wb_nxt;
    wc_r     <= wc_nxt;
    chosen_r <= chosen_nxt;
    leader_r <= leader_nxt;
    best_r   <= best_nxt;
    stop_r   <= stop_nxt;
    err_r    <= err_nxt;
  end

endmodule

[sv/bagsel_checker.sv]
// Port-level checks for the best-arm gap selector, bound to the top level.
// Depends on bagsel_pkg and best_arm_gap_selector_unit.
module bagsel_checker import bagsel_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_last,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_chosen,
  input logic [ID_W-1:0] out_leader,
  input logic [ID_W-1:0] out_best,
  input logic            out_stop,
  input logic            out_err
);

  logic [3:0] open_sets_r;

  // Sets closed on the input side whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_sets_r <= '0;
    end else begin
      open_sets_r <= open_sets_r + 4'(in_valid && in_ready && in_last)
                     - 4'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen) && $stable(out_leader) &&
                               $stable(out_best) && $stable(out_stop) && $stable(out_err))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_sets_r != '0)
    else $error("result without a closed set");

  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_stop && out_chosen == out_leader && out_best == out_leader)
    else $error("error result fields inconsistent");

  a_best_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stop |-> out_best == out_leader)
    else $error("best arm differs from leader without stop");

endmodule

bind best_arm_gap_selector_unit bagsel_checker u_bagsel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_arm.valid),
  .in_ready   (in_arm.ready),
  .in_last    (in_arm.last_arm),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .out_chosen (out_res.chosen_arm),
  .out_leader (out_res.leader_arm),
  .out_best   (out_res.best_arm),
  .out_stop   (out_res.stop_found),
  .out_err    (out_res.all_same_error)
);

[test/tb.sv]
// Self-checking testbench for best_arm_gap_selector_unit: directed table, then random sets.
// Depends on bagsel_pkg, bagsel_if and the selector RTL; it needs no other file.
module tb;
  import bagsel_pkg::*;

  // Result of one closed set, as the selector reports it.
  typedef struct packed {
    logic [ID_W-1:0] chosen;
    logic [ID_W-1:0] leader;
    logic [ID_W-1:0] best;
    logic            stop;
    logic            err;
  } sel_t;

  // One row of the directed table. Rows with typed set carry their own expectation.
  typedef struct packed {
    arm_word_t arm;
    logic      last;
    logic      typed;
    sel_t      want;
  } dir_row_t;

  // Cycles to let pass before a register write: a full set scan plus margin.
  localparam int SETTLE     = MAX_ARMS + 16;
  localparam int DRAIN_MAX  = 50000;
  localparam int PHASE_ARMS = 90;
  localparam int NUM_PHASES = 8;

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  bagsel_in_if  in_arm_if ();
  bagsel_out_if out_res_if ();

  best_arm_gap_selector_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_arm   (in_arm_if),
    .out_res  (out_res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: the stored set, the running leader and the recorded stop feature.
  logic [ID_W-1:0]           arm_id_mem  [MAX_ARMS];
  logic signed [BOUND_W-1:0] arm_lo_mem  [MAX_ARMS];
  logic signed [BOUND_W-1:0] arm_up_mem  [MAX_ARMS];
  logic [TAG_W-1:0]          arm_tag_mem [MAX_ARMS];
  int                        arm_cnt;
  int                        lead;
  bit                        differ;
  bit                        sf_seen;
  logic signed [BOUND_W-1:0] sf_lower;
  logic [EPS_W-1:0]          eps_reg;
  logic [ID_W-1:0]           sf_reg;

  sel_t     pending_sel[$];
  dir_row_t dir_rows[$];

  int idle_pct;
  int stall_pct;
  int fail_cnt;
  int arms_sent;
  int sets_sent;
  int overflow_sets;
  int results_seen;
  int stop_seen;
  int err_seen;
  int settings_used;

  // Folds one accepted arm into the predicted set. When the arm closes the set, the
  // selection is worked out into sel and 1 is returned; the set then starts over.
  function automatic bit absorb_arm(input arm_word_t a, input bit last, output sel_t sel);
    int k;
    int rival;
    bit have_rival;
    logic signed [DIFF_W-1:0] ldr_lo, ldr_up, riv_lo, riv_up, sf_lo;
    logic signed [DIFF_W-1:0] eps_w, gap, ldr_w, riv_w;
    sel = '0;
    // Arms past the end of the store are dropped, but their last flag still counts.
    if (arm_cnt < MAX_ARMS) begin
      k = arm_cnt;
      arm_id_mem[k]  = a.id;
      arm_lo_mem[k]  = a.lower;
      arm_up_mem[k]  = a.upper;
      arm_tag_mem[k] = a.tag;
      if (k > 0) begin
        if (a.tag != arm_tag_mem[0]) differ = 1'b1;
        if (arm_lo_mem[k] > arm_lo_mem[lead]) lead = k;
      end else begin
        lead = 0;
      end
      if (!sf_seen && a.id == sf_reg) begin
        sf_seen  = 1'b1;
        sf_lower = a.lower;
      end
      arm_cnt = k + 1;
    end
    if (!last) return 1'b0;

    if (!differ) begin
      // Every tag equal, a lone arm included: report the first arm with error and stop.
      sel.chosen = arm_id_mem[0];
      sel.leader = arm_id_mem[0];
      sel.best   = arm_id_mem[0];
      sel.stop   = 1'b1;
      sel.err    = 1'b1;
    end else begin
      have_rival = 1'b0;
      rival = 0;
      for (int i = 0; i < arm_cnt; i++) begin
        if (arm_tag_mem[i] != arm_tag_mem[lead]) begin
          if (!have_rival || arm_up_mem[i] > arm_up_mem[rival]) begin
            rival = i;
            have_rival = 1'b1;
          end
        end
      end
      // All differences are taken one bit wider than the bounds, so none can wrap.
      ldr_lo = arm_lo_mem[lead];
      ldr_up = arm_up_mem[lead];
      riv_lo = arm_lo_mem[rival];
      riv_up = arm_up_mem[rival];
      sf_lo  = sf_lower;
      eps_w  = {2'b00, eps_reg};
      gap    = riv_up - ldr_lo;
      sel.stop   = (gap <= eps_w);
      sel.leader = arm_id_mem[lead];
      sel.best   = arm_id_mem[lead];
      if (sel.stop && sf_seen && (ldr_lo - sf_lo <= eps_w)) sel.best = sf_reg;
      ldr_w = ldr_up - ldr_lo;
      riv_w = riv_up - riv_lo;
      sel.chosen = (riv_w > ldr_w) ? arm_id_mem[rival] : arm_id_mem[lead];
      sel.err    = 1'b0;
    end
    arm_cnt  = 0;
    lead     = 0;
    differ   = 1'b0;
    sf_seen  = 1'b0;
    sf_lower = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  function automatic void add_row(input int id, input logic [BOUND_W-1:0] lo,
                                  input logic [BOUND_W-1:0] up, input int tag,
                                  input bit last, input bit typed, input int c,
                                  input int l, input int b, input bit s, input bit e);
    dir_row_t row;
    row.arm.id      = ID_W'(id);
    row.arm.lower   = lo;
    row.arm.upper   = up;
    row.arm.tag     = TAG_W'(tag);
    row.last        = last;
    row.typed       = typed;
    row.want.chosen = ID_W'(c);
    row.want.leader = ID_W'(l);
    row.want.best   = ID_W'(b);
    row.want.stop   = s;
    row.want.err    = e;
    dir_rows.push_back(row);
  endfunction

  // A bound drawn from the corners of the signed range, or plain random.
  function automatic logic [BOUND_W-1:0] corner_bound();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Offers one arm, starting at a falling edge, and holds it until the transfer. The
  // predictor sees the arm at the edge of the transfer. Valid is left high afterward so
  // that a following arm goes out back to back; the caller lowers it at phase end.
  task automatic send_arm(input arm_word_t a, input bit last, input bit typed,
                          input sel_t want);
    sel_t sel;
    bit got;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_arm_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_arm_if.valid       <= 1'b1;
    in_arm_if.feature_id  <= a.id;
    in_arm_if.lower_bound <= a.lower;
    in_arm_if.upper_bound <= a.upper;
    in_arm_if.group_tag   <= a.tag;
    in_arm_if.last_arm    <= last;
    @(posedge clk);
    while (!in_arm_if.ready) @(posedge clk);
    if (arm_cnt < MAX_ARMS) arms_sent++;
    if (last) sets_sent++;
    got = absorb_arm(a, last, sel);
    if (typed) pending_sel.push_back(want);
    else if (got) pending_sel.push_back(sel);
    @(negedge clk);
  endtask

  // Writes both registers on consecutive falling edges, with the enable held between.
  task automatic apply_settings(input logic [EPS_W-1:0] eps, input logic [ID_W-1:0] sf);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAP_EPSILON;
    cfg_wdata <= eps;
    eps_reg    = eps;
    @(negedge clk);
    cfg_index <= CFG_STOP_FEATURE;
    cfg_wdata <= CFG_W'(sf);
    sf_reg     = sf;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Waits for every expected result, then lets the block settle. Ends at a falling edge.
  task automatic drain();
    int waited;
    waited = 0;
    while (pending_sel.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_sel.size() != 0) begin
      $error("%0d expected results never arrived", pending_sel.size());
      fail_cnt++;
      pending_sel.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // One random set. Most sets are short; a few fill the store and some run past it.
  // Bounds are clustered so that stop decisions are close calls, fully random so that
  // every bit toggles, or taken from the corners of the range.
  task automatic run_random_set();
    int n;
    int vmode;
    int tmode;
    int r;
    logic [BOUND_W-1:0] center;
    logic [TAG_W-1:0]   base_tag;
    arm_word_t a;
    sel_t dummy;
    r = $urandom_range(0, 99);
    if (r < 70)      n = $urandom_range(1, 8);
    else if (r < 92) n = $urandom_range(9, 40);
    else if (r < 97) n = $urandom_range(41, MAX_ARMS);
    else             n = $urandom_range(MAX_ARMS + 1, MAX_ARMS + 6);
    if (n > MAX_ARMS) overflow_sets++;
    vmode    = $urandom_range(0, 2);
    r        = $urandom_range(0, 99);
    tmode    = (r < 10) ? 0 : (r < 70) ? 1 : 2;
    center   = $urandom;
    base_tag = TAG_W'($urandom_range(0, 65535));
    dummy    = '0;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30)      a.id = sf_reg;
      else if (r < 45) a.id = $urandom_range(0, 1) ? '1 : '0;
      else             a.id = ID_W'($urandom_range(0, 1023));
      case (vmode)
        0: begin
          a.lower = center + $urandom_range(0, 32'h0003_0000);
          a.upper = a.lower + $urandom_range(0, 32'h0003_0000) - 32'h0000_8000;
        end
        1: begin
          a.lower = $urandom;
          a.upper = $urandom;
        end
        default: begin
          a.lower = corner_bound();
          a.upper = corner_bound();
        end
      endcase
      case (tmode)
        0:       a.tag = base_tag;
        1:       a.tag = base_tag + TAG_W'($urandom_range(0, 2));
        default: a.tag = TAG_W'($urandom_range(0, 65535));
      endcase
      send_arm(a, k == n - 1, 1'b0, dummy);
    end
  endtask

  // Receiver: decides ready for the next edge at every falling edge.
  initial begin
    out_res_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      out_res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    sel_t want;
    if (rst_n && out_res_if.valid && out_res_if.ready) begin
      if (pending_sel.size() == 0) begin
        $error("result with no expectation: chosen_arm %0d leader_arm %0d",
               out_res_if.chosen_arm, out_res_if.leader_arm);
        fail_cnt++;
      end else begin
        want = pending_sel.pop_front();
        check_field("chosen_arm", want.chosen, out_res_if.chosen_arm);
        check_field("leader_arm", want.leader, out_res_if.leader_arm);
        check_field("best_arm", want.best, out_res_if.best_arm);
        check_field("stop_found", want.stop, out_res_if.stop_found);
        check_field("all_same_error", want.err, out_res_if.all_same_error);
        results_seen++;
        if (out_res_if.stop_found) stop_seen++;
        if (out_res_if.all_same_error) err_seen++;
      end
    end
  end

  // Hard limit on the run, far beyond the slowest correct schedule.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [EPS_W-1:0] eps;
    logic [ID_W-1:0]  sf;
    int phase_start;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_GAP_EPSILON;
    cfg_wdata = '0;
    in_arm_if.valid       = 1'b0;
    in_arm_if.feature_id  = '0;
    in_arm_if.lower_bound = '0;
    in_arm_if.upper_bound = '0;
    in_arm_if.group_tag   = '0;
    in_arm_if.last_arm    = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    fail_cnt  = 0;
    arms_sent = 0;
    sets_sent = 0;
    overflow_sets = 0;
    results_seen  = 0;
    stop_seen     = 0;
    err_seen      = 0;
    settings_used = 0;
    // Predictor starts from the reset state of the block.
    arm_cnt  = 0;
    lead     = 0;
    differ   = 1'b0;
    sf_seen  = 1'b0;
    sf_lower = '0;
    eps_reg  = '0;
    sf_reg   = '0;

    // Directed table, run with the reset values of both registers (tolerance zero,
    // stop feature zero). Typed rows are the ones whose outcome is plain by eye.
    // A lone arm at the top id with opposite extreme bounds: all tags equal.
    add_row(1023, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1, 1, 1023, 1023, 1023, 1, 1);
    // A lone arm at id zero, which is also the stop feature, upper below lower.
    add_row(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1, 0, 0, 0, 1, 1);
    // Two arms sharing a tag: error case reports the first arm.
    add_row(5, 10, 20, 16'h1234, 0, 0, 0, 0, 0, 0, 0);
    add_row(6, 30, 40, 16'h1234, 1, 1, 5, 5, 5, 1, 1);
    // Leader at the top of the range, challenger at the bottom: gap far below zero.
    add_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(2, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1, 1, 1, 1, 1, 1, 0);
    // Challenger with the widest possible interval and a gap at the top of the range.
    add_row(3, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(4, 0, 0, 2, 1, 1, 3, 4, 4, 0, 0);
    // Ties on lower and on upper bound, stop feature loaded and then repeated.
    add_row(7, 100, 200, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(8, 100, 300, 2, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 50, 300, 3, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 100, 100, 1, 1, 0, 0, 0, 0, 0, 0);
    // Gap exactly at the tolerance with the stop feature tied to the leader.
    add_row(9, 500, 600, 4, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 500, 700, 4, 0, 0, 0, 0, 0, 0, 0);
    add_row(10, -5, 500, 5, 1, 0, 0, 0, 0, 0, 0);
    // Stop feature absent, leader last in the set, challenger first.
    add_row(11, -100, 900, 6, 0, 0, 0, 0, 0, 0, 0);
    add_row(12, 800, 850, 7, 0, 0, 0, 0, 0, 0, 0);
    add_row(13, 900, 950, 8, 1, 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_arm(dir_rows[i].arm, dir_rows[i].last, dir_rows[i].typed,
                                   dir_rows[i].want);
    in_arm_if.valid <= 1'b0;
    drain();

    // Random phases. Idling cycles through none, sender only, receiver only and both,
    // while the registers move between their extremes and random values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      case (p)
        0: begin eps = '1; sf = '1; end
        1: begin eps = '0; sf = '0; end
        2: begin eps = EPS_W'(32'h0001_0000); sf = ID_W'($urandom_range(0, 1023)); end
        3: begin
          eps = EPS_W'($urandom_range(0, 32'h7FFF_FFFF));
          sf  = ID_W'($urandom_range(0, 1023));
        end
        4: begin
          eps = EPS_W'($urandom_range(0, 32'h0004_0000));
          sf  = ID_W'($urandom_range(0, 1023));
        end
        5: begin eps = '1; sf = '0; end
        6: begin eps = EPS_W'($urandom_range(0, 32'h0004_0000)); sf = '1; end
        default: begin
          eps = EPS_W'($urandom_range(0, 32'h7FFF_FFFF));
          sf  = ID_W'($urandom_range(0, 1023));
        end
      endcase
      apply_settings(eps, sf);
      phase_start = arms_sent;
      while (arms_sent - phase_start < PHASE_ARMS) run_random_set();
      in_arm_if.valid <= 1'b0;
      drain();
    end

    $display("Sent %0d stored arms in %0d sets (%0d past the store size) over %0d settings.",
             arms_sent, sets_sent, overflow_sets, settings_used);
    $display("Checked %0d results: %0d with stop, %0d with all tags equal.",
             results_seen, stop_seen, err_seen);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
